>>> hw/rtl/atcfp_pkg.sv
package atcfp_pkg;

    // byte codes that the parser reacts to
    localparam logic [7:0] CHAR_DATA   = 8'h44;  // 'D'
    localparam logic [7:0] CHAR_INFO   = 8'h49;  // 'I'
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;

    // result item layout
    localparam int CH_W       = 16;
    localparam int FOUND_W    = 2;
    localparam int SET_W      = 32;
    localparam int NUM_CH     = 3;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_BITS   = NUM_CH * CH_W + FOUND_W + SET_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [CH_W-1:0] ch_value_t;

endpackage

>>> hw/rtl/ascii_three_channel_frame_parser.sv
// Byte-stream frame parser: one ASCII byte per item on the s_ side, one item per
// closed 'D' frame on the m_ side. Bytes are parsed in the cycle they are taken, so
// the block takes one byte every clock cycle; the only stall is when its single
// result register still holds an item the downstream side has not taken and that
// side is not taking it in this cycle. Values saturate to VALUE_WIDTH signed bits
// and appear as the low 16 bits of that form (zero-extended for narrower widths).
// m_tdata carries, from bit 0 up: ch1_value[15:0], ch2_value[15:0],
// ch3_value[15:0], values_found[1:0], set_count[31:0], then zero padding.
module ascii_three_channel_frame_parser #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [atcfp_pkg::IN_TDATA_W-1:0]     s_tdata,   // rx_byte[7:0]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [atcfp_pkg::OUT_TDATA_W-1:0]    m_tdata    // ch1, ch2, ch3, found, set
);
    import atcfp_pkg::*;

    localparam int ACC_W = VALUE_WIDTH;
    localparam int PROD_W = VALUE_WIDTH + 4;
    localparam logic [ACC_W-1:0] MAG_LIMIT = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] POS_LIMIT = {1'b0, {(ACC_W-1){1'b1}}};

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_DATA,
        MODE_INFO
    } mode_t;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SPACE,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    mode_t               mode_reg, mode_next;
    phase_t              phase_reg, phase_next;
    logic [1:0]          idx_reg, idx_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                neg_reg, neg_next;
    ch_value_t           store_reg [NUM_CH];
    ch_value_t           store_next [NUM_CH];
    logic [SET_W-1:0]    set_reg, set_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [7:0]          c;
    logic                accept;
    logic                is_marker, is_digit, is_space, is_sign;
    logic [PROD_W-1:0]   prod;
    logic [ACC_W-1:0]    acc_digit;
    logic [ACC_W-1:0]    sat_mag;
    logic [ACC_W-1:0]    sat_val;
    ch_value_t           commit_val;
    logic                close_commit;
    ch_value_t           out_ch [NUM_CH];
    logic [1:0]          out_found;

    assign c        = s_tdata;
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // byte classes
    assign is_marker = (c == CHAR_DATA) || (c == CHAR_INFO);
    assign is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign is_space  = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    assign is_sign   = (c == CHAR_PLUS) || (c == CHAR_MINUS);

    // accumulator times ten plus digit, saturated at the magnitude limit
    assign prod = (PROD_W'(acc_reg) << 3) + (PROD_W'(acc_reg) << 1) + PROD_W'(c[3:0]);
    assign acc_digit = (prod > PROD_W'(MAG_LIMIT)) ? MAG_LIMIT : prod[ACC_W-1:0];

    // saturated signed value of the number being read
    always_comb begin
        if (neg_reg) begin
            sat_mag = (acc_reg > MAG_LIMIT) ? MAG_LIMIT : acc_reg;
            sat_val = ACC_W'(0) - sat_mag;
        end else begin
            sat_mag = (acc_reg > POS_LIMIT) ? POS_LIMIT : acc_reg;
            sat_val = sat_mag;
        end
    end
    assign commit_val = CH_W'(sat_val);

    // values of a data frame that a marker closes
    assign close_commit = (phase_reg == PH_DIGITS) && (idx_reg < 2'd3);
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            out_ch[i] = (close_commit && (idx_reg == 2'(i))) ? commit_val : store_reg[i];
        end
        out_found = close_commit ? idx_reg + 2'd1 : idx_reg;
    end

    // parser next state
    always_comb begin
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        store_next   = store_reg;
        set_next     = set_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        if (accept) begin
            if (is_marker) begin
                if (mode_reg == MODE_DATA) begin
                    set_next     = set_reg + SET_W'(1);
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_TDATA_W'({set_next, out_found,
                                                 out_ch[2], out_ch[1], out_ch[0]});
                end
                mode_next  = (c == CHAR_DATA) ? MODE_DATA : MODE_INFO;
                phase_next = PH_SKIP;
                idx_next   = 2'd0;
                acc_next   = '0;
                neg_next   = 1'b0;
                for (int i = 0; i < NUM_CH; i++) begin
                    store_next[i] = '0;
                end
            end else if (mode_reg == MODE_DATA) begin
                case (phase_reg)
                    PH_SKIP: begin
                        phase_next = PH_SPACE;
                    end
                    PH_SPACE: begin
                        if (is_space) begin
                            phase_next = PH_SPACE;
                        end else if (is_digit) begin
                            acc_next   = ACC_W'(c[3:0]);
                            neg_next   = 1'b0;
                            phase_next = PH_DIGITS;
                        end else if (is_sign) begin
                            acc_next   = '0;
                            neg_next   = (c == CHAR_MINUS);
                            phase_next = PH_SIGN;
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_SIGN: begin
                        if (is_digit) begin
                            acc_next   = acc_digit;
                            phase_next = PH_DIGITS;
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DIGITS: begin
                        if (is_digit) begin
                            acc_next = acc_digit;
                        end else begin
                            // number ends here, store it
                            if (idx_reg < 2'd3) begin
                                store_next[idx_reg] = commit_val;
                                idx_next = idx_reg + 2'd1;
                            end
                            acc_next = '0;
                            neg_next = 1'b0;
                            if (idx_next == 2'd3) begin
                                phase_next = PH_DONE;
                            end else if (is_space) begin
                                phase_next = PH_SPACE;
                            end else if (is_sign) begin
                                neg_next   = (c == CHAR_MINUS);
                                phase_next = PH_SIGN;
                            end else begin
                                phase_next = PH_DONE;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    // state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            phase_reg   <= PH_SKIP;
            idx_reg     <= 2'd0;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
                store_reg[i] <= '0;
            end
            set_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            store_reg   <= store_next;
            set_reg     <= set_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

endmodule

>>> hw/rtl/atcfp_checker.sv
module atcfp_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [atcfp_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [atcfp_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import atcfp_pkg::*;

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a new result only follows a frame marker
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready &&
                                  (s_tdata == CHAR_DATA || s_tdata == CHAR_INFO)))
        else $error("result without a closing marker");

    // channels beyond the parsed count read zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[49:48] == 2'd0) |-> m_tdata[15:0] == 16'd0)
        else $error("first channel set with no values");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[49:48] != 2'd3) |->
            (m_tdata[47:32] == 16'd0) && (m_tdata[49:48] == 2'd2 || m_tdata[31:16] == 16'd0))
        else $error("unparsed channel not zero");

endmodule

bind ascii_three_channel_frame_parser atcfp_checker u_atcfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
